>>> sv/krah_pkg.sv
// Package for the key range access histogram: transfer payload types,
// request and status codes, controller command and status structs.
// No dependencies.
package krah_pkg;

    localparam int ACC_W       = 64;
    localparam int CNT_W       = 64;
    localparam int IDX_OUT_W   = 10;
    localparam int IDX_EXT_W   = 17;
    localparam int RANGE_SPAN  = 5;

    // floor(x / 5) == (x * RECIP_MUL) >> RECIP_SHIFT for every x below 2^DIV_IN_W
    localparam int DIV_IN_W    = 19;
    localparam int RECIP_W     = 20;
    localparam int PROD_W      = DIV_IN_W + RECIP_W;
    localparam int RECIP_SHIFT = 22;
    localparam logic [RECIP_W-1:0] RECIP_MUL = 20'd838861;

    localparam logic [7:0] DIGIT_ZERO = 8'h30;
    localparam logic [7:0] DIGIT_NINE = 8'h39;

    localparam logic [1:0] REQ_KEY   = 2'd0;
    localparam logic [1:0] REQ_DUMP  = 2'd1;
    localparam logic [1:0] REQ_EMPTY = 2'd2;
    localparam logic [1:0] REQ_NONE  = 2'd3;

    localparam logic [1:0] STATUS_COUNTED = 2'd0;
    localparam logic [1:0] STATUS_OOB     = 2'd1;
    localparam logic [1:0] STATUS_DUMP    = 2'd2;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] key_byte;
        logic       key_last;
        logic [9:0] dump_index;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [9:0]  range_index;
        logic [63:0] count_value;
    } out_item_t;

    typedef struct packed {
        logic acc_step;
        logic acc_clear;
        logic addr_key;
        logic addr_dump;
        logic addr_zero;
        logic res_oob;
        logic clr_we;
        logic rd_en;
        logic upd_we;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic key_ok;
        logic dump_ok;
    } stat_t;

endpackage

>>> sv/krah_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module krah_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/krah_ctrl.sv
// Controller of the key range access histogram: sequences clearing pass,
// key end, counter update and result hand-off. Depends on krah_pkg.
module krah_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  krah_pkg::in_item_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    input  krah_pkg::stat_t   stat,
    output krah_pkg::cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_RD,
        S_UPD,
        S_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   accept;
    logic   out_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_we = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    case (in_data.req_type)
                        krah_pkg::REQ_KEY:
                        begin
                            cmd.acc_step = 1'b1;
                            if (in_data.key_last)
                            begin
                                state_next = S_DIV;
                            end
                        end
                        krah_pkg::REQ_DUMP:
                        begin
                            if (stat.dump_ok)
                            begin
                                cmd.addr_dump = 1'b1;
                                state_next    = S_RD;
                            end
                            else
                            begin
                                cmd.res_oob = 1'b1;
                                state_next  = S_EMIT;
                            end
                        end
                        krah_pkg::REQ_EMPTY:
                        begin
                            cmd.acc_clear = 1'b1;
                            cmd.addr_zero = 1'b1;
                            state_next    = S_RD;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_DIV:
            begin
                cmd.acc_clear = 1'b1;
                if (stat.key_ok)
                begin
                    cmd.addr_key = 1'b1;
                    state_next   = S_RD;
                end
                else
                begin
                    cmd.res_oob = 1'b1;
                    state_next  = S_EMIT;
                end
            end
            S_RD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_UPD;
            end
            S_UPD:
            begin
                cmd.upd_we = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_rd_then_upd: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RD |=> state_reg == S_UPD)
        else $error("counter read not followed by update");

    a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_EMIT)
        else $error("result raised outside hand-off state");

    a_unused_req_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_data.req_type == krah_pkg::REQ_NONE |=> state_reg == S_IDLE)
        else $error("unused request left idle state");

endmodule

>>> sv/krah_dp.sv
// Datapath of the key range access histogram: digit accumulator, divide by
// five, counter store with clearing sweep, result and output registers.
// Depends on krah_pkg and krah_ram.
module krah_dp #(
    parameter int RANGE_COUNT = 1024,
    parameter int IW          = (RANGE_COUNT > 1) ? $clog2(RANGE_COUNT) : 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  krah_pkg::in_item_t  in_data,
    input  krah_pkg::cmd_t      cmd,
    output krah_pkg::stat_t     stat,
    output krah_pkg::out_item_t out_data
);

    localparam logic [krah_pkg::ACC_W-1:0] KEY_LIMIT =
        krah_pkg::ACC_W'(RANGE_COUNT) * krah_pkg::ACC_W'(krah_pkg::RANGE_SPAN);
    localparam logic [krah_pkg::IDX_EXT_W-1:0] NR_EXT = krah_pkg::IDX_EXT_W'(RANGE_COUNT);
    localparam logic [IW-1:0] LAST_ADDR = IW'(RANGE_COUNT - 1);

    logic [krah_pkg::ACC_W-1:0]     acc_reg;
    logic [krah_pkg::ACC_W-1:0]     acc_next;
    logic                           ovf_reg;
    logic                           ovf_next;
    logic [IW-1:0]                  clr_cnt_reg;
    logic [IW-1:0]                  clr_cnt_next;
    logic                           is_dump_reg;
    logic                           is_dump_next;
    logic [IW-1:0]                  addr_reg;
    logic [IW-1:0]                  addr_next;
    krah_pkg::out_item_t            res_reg;
    krah_pkg::out_item_t            res_next;
    krah_pkg::out_item_t            out_reg;
    krah_pkg::out_item_t            out_next;

    logic                           is_digit;
    logic [3:0]                     digit;
    logic [krah_pkg::ACC_W+3:0]     step_sum;
    logic [krah_pkg::PROD_W-1:0]    quot_full;
    logic [krah_pkg::IDX_EXT_W-1:0] quot_ext;
    logic [krah_pkg::IDX_EXT_W-1:0] addr_ext;
    logic [krah_pkg::CNT_W-1:0]     rdata;
    logic [krah_pkg::CNT_W-1:0]     inc;
    logic                           ram_we;
    logic [IW-1:0]                  ram_waddr;
    logic [krah_pkg::CNT_W-1:0]     ram_wdata;

    always_comb
    begin
        is_digit = in_data.key_byte inside {[krah_pkg::DIGIT_ZERO:krah_pkg::DIGIT_NINE]};
        digit    = 4'(in_data.key_byte - krah_pkg::DIGIT_ZERO);
        step_sum = (krah_pkg::ACC_W+4)'({acc_reg, 3'b000})
                 + (krah_pkg::ACC_W+4)'({acc_reg, 1'b0})
                 + (krah_pkg::ACC_W+4)'(digit);
    end

    assign quot_full = krah_pkg::PROD_W'(acc_reg[krah_pkg::DIV_IN_W-1:0])
                     * krah_pkg::PROD_W'(krah_pkg::RECIP_MUL);
    assign quot_ext  = quot_full[krah_pkg::RECIP_SHIFT +: krah_pkg::IDX_EXT_W];
    assign addr_ext  = krah_pkg::IDX_EXT_W'(addr_reg);
    assign inc       = rdata + krah_pkg::CNT_W'(1);

    assign stat.clr_last = (clr_cnt_reg == LAST_ADDR);
    assign stat.key_ok   = !ovf_reg && (acc_reg < KEY_LIMIT);
    assign stat.dump_ok  = krah_pkg::IDX_EXT_W'(in_data.dump_index) < NR_EXT;

    always_comb
    begin
        acc_next     = acc_reg;
        ovf_next     = ovf_reg;
        clr_cnt_next = clr_cnt_reg;
        is_dump_next = is_dump_reg;
        addr_next    = addr_reg;
        res_next     = res_reg;
        out_next     = out_reg;
        if (cmd.acc_clear)
        begin
            acc_next = '0;
            ovf_next = 1'b0;
        end
        else if (cmd.acc_step && is_digit)
        begin
            if (|step_sum[krah_pkg::ACC_W+3:krah_pkg::ACC_W])
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                acc_next = step_sum[krah_pkg::ACC_W-1:0];
            end
        end
        if (cmd.clr_we)
        begin
            clr_cnt_next = clr_cnt_reg + IW'(1);
        end
        if (cmd.addr_key)
        begin
            addr_next    = quot_ext[IW-1:0];
            is_dump_next = 1'b0;
        end
        else if (cmd.addr_dump)
        begin
            addr_next    = IW'(in_data.dump_index);
            is_dump_next = 1'b1;
        end
        else if (cmd.addr_zero)
        begin
            addr_next    = '0;
            is_dump_next = 1'b0;
        end
        if (cmd.res_oob)
        begin
            res_next = '{status: krah_pkg::STATUS_OOB, range_index: '0, count_value: '0};
        end
        else if (cmd.upd_we)
        begin
            res_next.status      = is_dump_reg ? krah_pkg::STATUS_DUMP
                                               : krah_pkg::STATUS_COUNTED;
            res_next.range_index = addr_ext[krah_pkg::IDX_OUT_W-1:0];
            res_next.count_value = is_dump_reg ? rdata : inc;
        end
        if (cmd.out_load)
        begin
            out_next = res_reg;
        end
    end

    always_comb
    begin
        ram_we    = cmd.clr_we || cmd.upd_we;
        ram_waddr = cmd.clr_we ? clr_cnt_reg : addr_reg;
        ram_wdata = (cmd.clr_we || is_dump_reg) ? '0 : inc;
    end

    krah_ram #(
        .WIDTH (krah_pkg::CNT_W),
        .DEPTH (RANGE_COUNT),
        .AW    (IW)
    ) u_counters (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.rd_en),
        .raddr (addr_reg),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg     <= '0;
            ovf_reg     <= 1'b0;
            clr_cnt_reg <= '0;
            is_dump_reg <= 1'b0;
        end
        else
        begin
            acc_reg     <= acc_next;
            ovf_reg     <= ovf_next;
            clr_cnt_reg <= clr_cnt_next;
            is_dump_reg <= is_dump_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
    end

    assign out_data = out_reg;

    a_key_addr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.addr_key |=> addr_ext < NR_EXT)
        else $error("key range index beyond counter store");

    a_key_addr_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.addr_key |-> stat.key_ok)
        else $error("counter addressed for an out-of-range key");

endmodule

>>> sv/key_range_access_histogram_core.sv
// Key range access histogram, top level: joins controller and datapath.
// Depends on krah_pkg, krah_ctrl, krah_dp and krah_ram.
//
// Input channel (in_valid/in_ready, in_data): one request per transfer.
// Key bytes build a decimal number from their ASCII digits; the byte marked
// key_last closes the key, whose number divided by five selects a range
// counter. A dump request reads and clears one counter; an empty key access
// counts range 0. Output channel (out_valid/out_ready, out_data): at most one
// result per request, from a register, so one waiting result does not hold
// off the next input transfer.
// Steps per request, accept to next accept: none for a key byte that is not
// last and for the unused request code; hand-off for an out-of-range dump;
// read, update, hand-off for a dump or empty access; divide, read, update,
// hand-off for the last key byte (divide, hand-off if out of range), from
// the counter read-modify-write through one RAM port with registered read
// data. The result is shown in the same cycle as in_ready rises again.
// After reset the counter store is swept to zero, one entry per cycle, over all
// RANGE_COUNT entries with in_ready low. A stalled result holds in the output
// register and the next finished result waits in the controller until it
// has been taken.
module key_range_access_histogram_core #(
    parameter int RANGE_COUNT = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  krah_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output krah_pkg::out_item_t out_data
);

    krah_pkg::cmd_t  cmd;
    krah_pkg::stat_t stat;

    krah_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    krah_dp #(
        .RANGE_COUNT (RANGE_COUNT)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .cmd      (cmd),
        .stat     (stat),
        .out_data (out_data)
    );

endmodule

>>> dv/krah_tb_pkg.sv
// Test support for the key range access histogram: a scoreboard class that
// predicts range counts and dump values and checks each result transfer.
// Depends on krah_pkg.
package krah_tb_pkg;

    class histogram_board;

        int unsigned         range_total;
        bit [63:0]           digit_value;
        bit                  digit_overflow;
        bit [63:0]           range_count[];
        krah_pkg::out_item_t pending_reports[$];
        int                  errors;

        function new(int unsigned ranges);
            range_total    = ranges;
            range_count    = new[ranges];
            digit_value    = '0;
            digit_overflow = 1'b0;
            errors         = 0;
        endfunction

        function int pending();
            return pending_reports.size();
        endfunction

        function krah_pkg::out_item_t out_of_range();
            krah_pkg::out_item_t res;
            res.status      = krah_pkg::STATUS_OOB;
            res.range_index = '0;
            res.count_value = '0;
            return res;
        endfunction

        function krah_pkg::out_item_t bump_range(bit [63:0] idx);
            krah_pkg::out_item_t res;
            if (idx >= 64'(range_total))
            begin
                return out_of_range();
            end
            range_count[idx] = range_count[idx] + 64'd1;
            res.status      = krah_pkg::STATUS_COUNTED;
            res.range_index = idx[9:0];
            res.count_value = range_count[idx];
            return res;
        endfunction

        function void note_request(krah_pkg::in_item_t item);
            krah_pkg::out_item_t res;
            bit [63:0] digit;
            case (item.req_type)
                krah_pkg::REQ_KEY:
                begin
                    if (item.key_byte >= krah_pkg::DIGIT_ZERO &&
                        item.key_byte <= krah_pkg::DIGIT_NINE)
                    begin
                        digit = 64'(item.key_byte - krah_pkg::DIGIT_ZERO);
                        if (digit_value > (64'hFFFF_FFFF_FFFF_FFFF - digit) / 64'd10)
                            digit_overflow = 1'b1;
                        else
                            digit_value = digit_value * 64'd10 + digit;
                    end
                    if (item.key_last)
                    begin
                        if (digit_overflow)
                            res = out_of_range();
                        else
                            res = bump_range(digit_value / 64'(krah_pkg::RANGE_SPAN));
                        digit_value    = '0;
                        digit_overflow = 1'b0;
                        pending_reports.push_back(res);
                    end
                end
                krah_pkg::REQ_DUMP:
                begin
                    if (32'(item.dump_index) >= range_total)
                    begin
                        res = out_of_range();
                    end
                    else
                    begin
                        res.status      = krah_pkg::STATUS_DUMP;
                        res.range_index = item.dump_index;
                        res.count_value = range_count[item.dump_index];
                        range_count[item.dump_index] = '0;
                    end
                    pending_reports.push_back(res);
                end
                krah_pkg::REQ_EMPTY:
                begin
                    digit_value    = '0;
                    digit_overflow = 1'b0;
                    pending_reports.push_back(bump_range(64'd0));
                end
                default:
                begin
                end
            endcase
        endfunction

        function void check_report(krah_pkg::out_item_t got);
            krah_pkg::out_item_t want;
            if (pending_reports.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: status=%0d range=%0d count=%0d",
                             got.status, got.range_index, got.count_value);
                return;
            end
            want = pending_reports.pop_front();
            if (got.status !== want.status || got.range_index !== want.range_index ||
                got.count_value !== want.count_value)
            begin
                errors++;
                if (errors <= 10)
                    $display({"mismatch: expected status=%0d range=%0d count=%0d, ",
                              "got status=%0d range=%0d count=%0d"},
                             want.status, want.range_index, want.count_value,
                             got.status, got.range_index, got.count_value);
            end
        endfunction

    endclass

endpackage

>>> dv/tb.sv
// Testbench for key_range_access_histogram_core: drives key bytes, dumps and
// empty accesses with random bursts and output stalls, checks every result.
// Depends on krah_pkg and krah_tb_pkg.
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANGE_COUNT  = 1024;
    localparam int RANDOM_ITEMS = 810;
    localparam int HOLD_CYCLES  = 250;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    krah_pkg::in_item_t  in_data   = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    krah_pkg::out_item_t out_data;

    krah_tb_pkg::histogram_board board = new(RANGE_COUNT);

    int offered    = 0;
    int burst_left = 0;
    bit hold_req   = 1'b0;

    key_range_access_histogram_core #(
        .RANGE_COUNT(RANGE_COUNT)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_report(out_data);
    end

    task automatic offer(input logic [1:0] req, input logic [7:0] kb, input logic last,
                         input logic [9:0] idx, input bit steady = 1'b0);
        krah_pkg::in_item_t item;
        int gap;
        item.req_type   = req;
        item.key_byte   = kb;
        item.key_last   = last;
        item.dump_index = idx;
        if (!steady && burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        if (burst_left > 0)
            burst_left--;
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (!in_ready);
        board.note_request(item);
        offered++;
    endtask

    function automatic logic [7:0] non_digit();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255));
        while (b >= krah_pkg::DIGIT_ZERO && b <= krah_pkg::DIGIT_NINE);
        return b;
    endfunction

    function automatic logic [9:0] pick_index();
        if ($urandom_range(0, 1) == 1)
            return 10'($urandom_range(0, 24));
        return 10'($urandom_range(0, 1023));
    endfunction

    task automatic send_noise();
        case ($urandom_range(0, 2))
            0: offer(krah_pkg::REQ_KEY, non_digit(), 1'b0, 10'($urandom_range(0, 1023)));
            1: offer(krah_pkg::REQ_DUMP, 8'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1)), pick_index());
            default: offer(krah_pkg::REQ_NONE, 8'($urandom_range(0, 255)),
                           1'($urandom_range(0, 1)), 10'($urandom_range(0, 1023)));
        endcase
    endtask

    task automatic send_key(input string text, input int noise_pct);
        for (int i = 0; i < text.len(); i++)
        begin
            if ($urandom_range(0, 99) < noise_pct)
                send_noise();
            offer(krah_pkg::REQ_KEY, text[i], i == text.len() - 1,
                  10'($urandom_range(0, 1023)));
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (board.pending() != 0) @(posedge clk);
        @(posedge clk);
        burst_left = 0;
    endtask

    initial
    begin : receiver
        int phase_left;
        int mode;
        int period;
        int tick;
        int hold_left;
        phase_left = 0;
        mode       = 0;
        period     = 2;
        tick       = 0;
        hold_left  = 0;
        forever
        begin
            @(posedge clk);
            if (hold_left == 0 && hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                if (phase_left == 0)
                begin
                    phase_left = $urandom_range(20, 200);
                    mode       = $urandom_range(0, 3);
                    period     = $urandom_range(2, 6);
                end
                phase_left--;
                tick++;
                case (mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= 1'($urandom_range(0, 1));
                    2: out_ready <= (tick % period == 0);
                    default: out_ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    initial
    begin : stimulus
        string text;
        int pick;
        int n;
        bit held;
        bit paused;
        held   = 1'b0;
        paused = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        offer(krah_pkg::REQ_EMPTY, 8'h00, 1'b0, 10'd0);
        offer(krah_pkg::REQ_KEY, 8'h00, 1'b1, 10'h3FF);
        offer(krah_pkg::REQ_KEY, 8'hFF, 1'b0, 10'd0);
        offer(krah_pkg::REQ_KEY, 8'h2F, 1'b0, 10'd0);
        offer(krah_pkg::REQ_KEY, 8'h3A, 1'b0, 10'd0);
        offer(krah_pkg::REQ_KEY, krah_pkg::DIGIT_NINE, 1'b1, 10'd0);
        send_key("0", 0);
        send_key("5119", 0);
        send_key("5120", 0);
        offer(krah_pkg::REQ_KEY, "7", 1'b0, 10'd0);
        offer(krah_pkg::REQ_DUMP, 8'hFF, 1'b1, 10'h3FF);
        offer(krah_pkg::REQ_KEY, "8", 1'b1, 10'd0);
        offer(krah_pkg::REQ_KEY, "3", 1'b0, 10'd0);
        offer(krah_pkg::REQ_EMPTY, 8'hFF, 1'b1, 10'h3FF);
        offer(krah_pkg::REQ_DUMP, 8'h00, 1'b0, 10'd0);
        offer(krah_pkg::REQ_DUMP, 8'h00, 1'b0, 10'd0);
        offer(krah_pkg::REQ_NONE, 8'hFF, 1'b1, 10'h3FF);
        send_key("99999999999999999999", 0);

        n = offered;
        while (offered - n < RANDOM_ITEMS)
        begin
            if (!held && offered - n > 300)
            begin
                held     = 1'b1;
                hold_req = 1'b1;
                repeat (12) offer(krah_pkg::REQ_EMPTY, 8'($urandom_range(0, 255)),
                                  1'($urandom_range(0, 1)), 10'($urandom_range(0, 1023)),
                                  1'b1);
            end
            if (!paused && offered - n > 600)
            begin
                paused = 1'b1;
                wait_drained();
            end
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                if ($urandom_range(0, 1) == 1)
                    text = $sformatf("%0d", $urandom_range(0, 99));
                else
                    text = $sformatf("%0d", $urandom_range(0, 9999));
                if ($urandom_range(0, 9) < 3)
                    repeat ($urandom_range(1, 2)) text = {"0", text};
                send_key(text, 15);
            end
            else if (pick < 62)
            begin
                case ($urandom_range(0, 3))
                    0: text = "18446744073709551615";
                    1: text = "18446744073709551616";
                    default:
                    begin
                        text = "";
                        repeat ($urandom_range(18, 22))
                            text = $sformatf("%s%0d", text, $urandom_range(0, 9));
                    end
                endcase
                send_key(text, 5);
            end
            else if (pick < 75)
            begin
                offer(krah_pkg::REQ_DUMP, 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)), pick_index());
            end
            else if (pick < 82)
            begin
                offer(krah_pkg::REQ_EMPTY, 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)), 10'($urandom_range(0, 1023)));
            end
            else if (pick < 87)
            begin
                offer(krah_pkg::REQ_NONE, 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)), 10'($urandom_range(0, 1023)));
            end
            else if (pick < 92)
            begin
                repeat ($urandom_range(1, 3))
                    offer(krah_pkg::REQ_KEY, 8'(krah_pkg::DIGIT_ZERO + $urandom_range(0, 9)),
                          1'b0, 10'($urandom_range(0, 1023)));
                offer(krah_pkg::REQ_EMPTY, 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)), 10'($urandom_range(0, 1023)));
            end
            else
            begin
                repeat ($urandom_range(0, 2))
                    offer(krah_pkg::REQ_KEY, non_digit(), 1'b0, 10'($urandom_range(0, 1023)));
                offer(krah_pkg::REQ_KEY, non_digit(), 1'b1, 10'($urandom_range(0, 1023)));
            end
        end

        in_valid <= 1'b0;
        while (board.pending() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (board.errors == 0 && board.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin : watchdog
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
